@@ rtl/core/mau_pkg.sv @@
// Package for the modular arithmetic unit: widths, opcodes, sequencer states.
// No dependencies.
`default_nettype none
package mau_pkg;
  localparam int MOD_WIDTH = 31;
  localparam int EXP_WIDTH = 64;
  localparam int A_WIDTH = 32;
  localparam int B_WIDTH = 64;
  localparam int OP_WIDTH = 3;
  localparam int ADDR_WIDTH = 2;
  localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(1000000007);

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_POW = 3'd4, OP_INV = 3'd5, OP_NEG = 3'd6, OP_NONE = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0
  } reg_addr_t;

  // shared unit commands
  typedef enum logic [1:0] {
    U_RED = 2'd0,   // x mod m, restoring, 64-bit dividend
    U_MUL = 2'd1,   // x*y mod m, shift and add
    U_DIV = 2'd2    // x / y and remainder (Euclid step)
  } ucmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RED_A, S_RED_B, S_DISPATCH, S_INV_DIV, S_INV_Q, S_INV_MUL,
    S_INV_UPD, S_INV_END, S_POW_CHK, S_POW_MUL, S_POW_SQR, S_DIV_MUL, S_DONE
  } state_t;
endpackage
`default_nettype wire

@@ rtl/core/mau_if.sv @@
// Valid/ready channel interface carrying one payload type.
// Depends on nothing.
`default_nettype none
interface mau_if #(parameter type payload_t = logic) (input wire logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/modular_arithmetic_unit_top.sv @@
// Top level of the modular arithmetic unit: APB modulus register, sequencer.
// Depends on mau_pkg, mau_if, mau_unit.
//
//  channel  | dir | payload
//  in_ch    | in  | op, operand_a, operand_b
//  out_ch   | out | result, no_inverse
//  apb      | in  | modulus at address 0
//
// One item at a time; ready is low while an item is at work.
// Each unit call steps through 64 bits; add is 2 calls,
// mul 3, power up to 2 + 2*63 calls plus an Euclid inverse (up to ~46 rounds of 3 calls).
// The worst item is set by the one shared bit-serial unit.
// Reset is synchronous and restores the modulus to 1000000007.
// A result waits in its own output register while the next item is taken; a second
// result holds the sequencer in its last state until the first one is taken.
`default_nettype none
module modular_arithmetic_unit_top (
  input  wire logic clk,
  input  wire logic rst,
  mau_if.sink in_ch,
  mau_if.source out_ch,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [mau_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [mau_pkg::MOD_WIDTH-1:0] modulus;
  logic [63:0] m;
  mau_pkg::state_t state;
  mau_pkg::state_t state_next;
  mau_pkg::op_t op;
  logic aneg, bneg;
  logic [63:0] amag, bmag, a, b;
  logic [63:0] r0, r1, u, v, q, acc, base, e;
  logic err;
  logic started;
  logic u_start, u_busy, u_done;
  mau_pkg::ucmd_t u_cmd;
  logic [63:0] u_x, u_y, u_quo, u_rem;
  logic [63:0] subv;
  logic res_load;
  logic [mau_pkg::MOD_WIDTH-1:0] res_value;
  logic res_err;

  assign pready = 1'b1;
  assign prdata = (paddr == mau_pkg::REG_MODULUS) ? 32'(modulus) : '0;
  assign m = (modulus == '0) ? 64'd1 : 64'(modulus);
  assign in_ch.ready = (state == mau_pkg::S_IDLE);
  assign res_load = (state == mau_pkg::S_DONE) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mau_pkg::MOD_RESET;
    end else if (psel && penable && pwrite && paddr == mau_pkg::REG_MODULUS) begin
      modulus <= pwdata[mau_pkg::MOD_WIDTH-1:0];
    end
  end

  mau_unit u_unit (
    .clk(clk), .rst(rst), .start(u_start), .cmd(u_cmd), .x(u_x), .y(u_y), .m(m),
    .busy(u_busy), .done(u_done), .quo(u_quo), .rem(u_rem)
  );

  // u - v*q mod m for Euclid update
  assign subv = (u >= u_rem) ? u - u_rem : u + (m - u_rem);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mau_pkg::S_IDLE: if (in_ch.valid && in_ch.ready) state_next = mau_pkg::S_RED_A;
      mau_pkg::S_RED_A: if (u_done) state_next = mau_pkg::S_RED_B;
      mau_pkg::S_RED_B: if (u_done) state_next = mau_pkg::S_DISPATCH;
      mau_pkg::S_DISPATCH: begin
        case (op)
          mau_pkg::OP_MUL: state_next = mau_pkg::S_DIV_MUL;
          mau_pkg::OP_DIV, mau_pkg::OP_INV: state_next = mau_pkg::S_INV_DIV;
          mau_pkg::OP_POW:
            state_next = e[63] ? mau_pkg::S_INV_DIV : mau_pkg::S_POW_CHK;
          default: state_next = mau_pkg::S_DONE;
        endcase
      end
      mau_pkg::S_INV_DIV:
        if (r1 == '0) state_next = mau_pkg::S_INV_END;
        else if (u_done) state_next = mau_pkg::S_INV_Q;
      mau_pkg::S_INV_Q: if (u_done) state_next = mau_pkg::S_INV_MUL;
      mau_pkg::S_INV_MUL: if (u_done) state_next = mau_pkg::S_INV_UPD;
      mau_pkg::S_INV_UPD: state_next = mau_pkg::S_INV_DIV;
      mau_pkg::S_INV_END: begin
        if (r0 != 64'd1 || op == mau_pkg::OP_INV) state_next = mau_pkg::S_DONE;
        else if (op == mau_pkg::OP_DIV) state_next = mau_pkg::S_DIV_MUL;
        else state_next = mau_pkg::S_POW_CHK;
      end
      mau_pkg::S_POW_CHK:
        if (e == '0) state_next = mau_pkg::S_DONE;
        else state_next = e[0] ? mau_pkg::S_POW_MUL : mau_pkg::S_POW_SQR;
      mau_pkg::S_POW_MUL: if (u_done) state_next = mau_pkg::S_POW_SQR;
      mau_pkg::S_POW_SQR: if (u_done) state_next = mau_pkg::S_POW_CHK;
      mau_pkg::S_DIV_MUL: if (u_done) state_next = mau_pkg::S_DONE;
      // hold until the output register is free
      mau_pkg::S_DONE: if (res_load) state_next = mau_pkg::S_IDLE;
      default: state_next = mau_pkg::S_IDLE;
    endcase
  end

  // unit command
  always_comb begin
    u_cmd = mau_pkg::U_RED;
    u_x = '0;
    u_y = '0;
    case (state)
      mau_pkg::S_RED_A: u_x = amag;
      mau_pkg::S_RED_B: u_x = bmag;
      mau_pkg::S_INV_DIV: begin u_cmd = mau_pkg::U_DIV; u_x = r0; u_y = r1; end
      mau_pkg::S_INV_Q: u_x = q;
      mau_pkg::S_INV_MUL: begin u_cmd = mau_pkg::U_MUL; u_x = v; u_y = q; end
      mau_pkg::S_POW_MUL: begin u_cmd = mau_pkg::U_MUL; u_x = base; u_y = acc; end
      mau_pkg::S_POW_SQR: begin u_cmd = mau_pkg::U_MUL; u_x = base; u_y = base; end
      mau_pkg::S_DIV_MUL: begin u_cmd = mau_pkg::U_MUL; u_x = a; u_y = b; end
      default: ;
    endcase
  end

  assign u_start = !started && !u_busy && !u_done &&
    (state == mau_pkg::S_RED_A || state == mau_pkg::S_RED_B ||
     (state == mau_pkg::S_INV_DIV && r1 != '0) || state == mau_pkg::S_INV_Q ||
     state == mau_pkg::S_INV_MUL || state == mau_pkg::S_POW_MUL ||
     state == mau_pkg::S_POW_SQR || state == mau_pkg::S_DIV_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mau_pkg::S_IDLE;
      started <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (u_start) started <= 1'b1;
      if (u_done) started <= 1'b0;
      if (res_load) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_value <= acc[mau_pkg::MOD_WIDTH-1:0];
      res_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mau_pkg::S_IDLE: begin
        op <= mau_pkg::op_t'(in_ch.data.op);
        aneg <= in_ch.data.operand_a[31];
        amag <= in_ch.data.operand_a[31]
                  ? 64'(33'h1_0000_0000 - {1'b0, in_ch.data.operand_a})
                  : 64'(in_ch.data.operand_a);
        bneg <= in_ch.data.operand_b[63];
        bmag <= in_ch.data.operand_b[63] ? -in_ch.data.operand_b : in_ch.data.operand_b;
        e <= in_ch.data.operand_b;
        err <= 1'b0;
      end
      mau_pkg::S_RED_A:
        if (u_done) a <= (aneg && u_rem != '0) ? m - u_rem : u_rem;
      mau_pkg::S_RED_B:
        if (u_done) b <= (bneg && u_rem != '0) ? m - u_rem : u_rem;
      mau_pkg::S_DISPATCH: begin
        r0 <= m;
        r1 <= (op == mau_pkg::OP_DIV) ? b : a;
        u <= '0;
        v <= (m == 64'd1) ? 64'd0 : 64'd1;
        base <= a;
        if (op == mau_pkg::OP_POW && e[63]) e <= -e;
        case (op)
          mau_pkg::OP_ADD: acc <= (a + b >= m) ? a + b - m : a + b;
          mau_pkg::OP_SUB: acc <= (a >= b) ? a - b : a + (m - b);
          mau_pkg::OP_NEG: acc <= (a == '0) ? '0 : m - a;
          mau_pkg::OP_NONE: acc <= '0;
          default: acc <= (m == 64'd1) ? 64'd0 : 64'd1;
        endcase
      end
      mau_pkg::S_INV_DIV:
        if (u_done) begin q <= u_quo; r0 <= r1; r1 <= u_rem; end
      mau_pkg::S_INV_Q: if (u_done) q <= u_rem;
      mau_pkg::S_INV_UPD: begin u <= v; v <= subv; end
      mau_pkg::S_INV_END: begin
        if (r0 != 64'd1) begin err <= 1'b1; acc <= '0; end
        else if (op == mau_pkg::OP_INV) acc <= u;
        else if (op == mau_pkg::OP_DIV) b <= u;
        else base <= u;
      end
      mau_pkg::S_POW_MUL: if (u_done) acc <= u_rem;
      mau_pkg::S_POW_SQR: if (u_done) begin base <= u_rem; e <= e >> 1; end
      mau_pkg::S_DIV_MUL: if (u_done) acc <= u_rem;
      default: ;
    endcase
  end

  // INV_UPD uses u_rem still holding the v*q product
  assign out_ch.data.result = res_value;
  assign out_ch.data.no_inverse = res_err;

  assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> state == mau_pkg::S_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == mau_pkg::S_DONE) |=> out_ch.valid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && res_err) |-> res_value == '0)
    else $error("error result not zero");
  assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> 64'(res_value) < m)
    else $error("result out of range");
endmodule
`default_nettype wire

@@ rtl/core/mau_unit.sv @@
// Shared bit-serial unit: 64/m reduction, modular multiply, and 64-bit divide.
// Depends on mau_pkg; one bit per cycle.
`default_nettype none
module mau_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire mau_pkg::ucmd_t cmd,
  input  wire logic [63:0] x,
  input  wire logic [63:0] y,
  input  wire logic [63:0] m,
  output logic busy,
  output logic done,
  output logic [63:0] quo,
  output logic [63:0] rem
);
  logic [63:0] xs;
  logic [63:0] ys;
  logic [63:0] mr;
  logic [6:0] cnt;
  mau_pkg::ucmd_t c;
  logic [64:0] trial;
  logic [64:0] dbl;
  logic [64:0] sum;
  logic [63:0] dbl_r;
  logic [63:0] sum_r;

  always_comb begin
    trial = {rem, xs[63]} - {1'b0, ys};
    dbl = {rem, 1'b0};
    dbl_r = (dbl >= {1'b0, mr}) ? 64'(dbl - {1'b0, mr}) : dbl[63:0];
    sum = {1'b0, dbl_r} + {1'b0, xs};
    sum_r = (sum >= {1'b0, mr}) ? 64'(sum - {1'b0, mr}) : sum[63:0];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      c <= cmd;
      cnt <= 7'd64;
      rem <= '0;
      quo <= '0;
      mr <= m;
      case (cmd)
        mau_pkg::U_RED: begin xs <= x; ys <= m; end
        mau_pkg::U_MUL: begin xs <= x; ys <= y; end
        default: begin xs <= x; ys <= y; end
      endcase
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      if (c == mau_pkg::U_MUL) begin
        // Horner over multiplier bits, msb first
        rem <= ys[63] ? sum_r : dbl_r;
        ys <= {ys[62:0], 1'b0};
      end else begin
        xs <= {xs[62:0], 1'b0};
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], xs[63]};
          quo <= {quo[62:0], 1'b0};
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("unit not busy after start");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("unit done while busy");
  assert property (@(posedge clk) disable iff (rst)
    (busy && !start && c == mau_pkg::U_MUL) |-> rem < mr)
    else $error("mul accumulator out of range");
endmodule
`default_nettype wire
